@@ design/strided_fft_power_spectrum_core_macros.svh @@
// Assertion macros used by the DFT engine design file.
`ifndef STRIDED_FFT_POWER_SPECTRUM_CORE_MACROS_SVH
`define STRIDED_FFT_POWER_SPECTRUM_CORE_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define SFPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sfps assertion failed");

// Condition that must never be true outside reset.
`define SFPS_NEVER(lbl, clk, rst_n, cond) \
    `SFPS_ASSERT(lbl, clk, rst_n, !(cond))

`endif

@@ design/sfps_pkg.sv @@
package sfps_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STRIDE_W = 16;
    localparam int WORK_W   = 22;
    localparam int POWER_W  = 44;
    localparam int BIN_W    = 6;
    localparam int TW_W     = 17;
    localparam int PHASE_W  = 6;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_ROUND,
        S_RD,
        S_SQ,
        S_SUM
    } t_state;

    // cos(2*pi*m/64) in Q2.15
    function automatic logic signed [TW_W-1:0] tw_cos(input logic [PHASE_W-1:0] m);
        logic [PHASE_W-1:0] d;
        logic [4:0] q;
        logic neg;
        logic signed [TW_W-1:0] mag;
        if (m <= 6'd16) begin
            d = m;
            neg = 1'b0;
        end else if (m <= 6'd32) begin
            d = 6'd32 - m;
            neg = 1'b1;
        end else if (m <= 6'd48) begin
            d = m - 6'd32;
            neg = 1'b1;
        end else begin
            d = 6'd0 - m;
            neg = 1'b0;
        end
        q = d[4:0];
        unique case (q)
            5'd0:    mag = 17'sd32768;
            5'd1:    mag = 17'sd32610;
            5'd2:    mag = 17'sd32138;
            5'd3:    mag = 17'sd31357;
            5'd4:    mag = 17'sd30274;
            5'd5:    mag = 17'sd28899;
            5'd6:    mag = 17'sd27246;
            5'd7:    mag = 17'sd25330;
            5'd8:    mag = 17'sd23170;
            5'd9:    mag = 17'sd20788;
            5'd10:   mag = 17'sd18205;
            5'd11:   mag = 17'sd15447;
            5'd12:   mag = 17'sd12540;
            5'd13:   mag = 17'sd9512;
            5'd14:   mag = 17'sd6393;
            5'd15:   mag = 17'sd3212;
            default: mag = 17'sd0;
        endcase
        return neg ? -mag : mag;
    endfunction

endpackage

@@ design/sfps_in_if.sv @@
interface sfps_in_if;
    import sfps_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

@@ design/sfps_out_if.sv @@
interface sfps_out_if;
    import sfps_pkg::*;
    logic               valid;
    logic               ready;
    logic [BIN_W-1:0]   bin_index;
    logic [POWER_W-1:0] bin_power;
    logic               last_bin;

    modport source (output valid, output bin_index, output bin_power, output last_bin,
                    input ready);
    modport sink (input valid, input bin_index, input bin_power, input last_bin,
                  output ready);
endinterface

@@ design/sfps_ram.sv @@
module sfps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/sfps_dft_engine.sv @@
`include "strided_fft_power_spectrum_core_macros.svh"

module sfps_dft_engine
    import sfps_pkg::*;
#(
    parameter int FFT_SIZE = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [$clog2(FFT_SIZE)-1:0] i_base,
    output logic                        o_idle,
    output logic [$clog2(FFT_SIZE)-1:0] o_win_addr,
    input  logic signed [SAMPLE_W-1:0]  i_win_data,
    sfps_out_if.source                  o_out
);
    localparam int AW      = $clog2(FFT_SIZE);
    localparam int HALF    = FFT_SIZE / 2;
    localparam int TW_STEP = 64 / FFT_SIZE;
    localparam int PROD_W  = SAMPLE_W + TW_W;
    localparam int ACC_W   = PROD_W + AW;
    localparam int EXT_W   = 40;

    t_state r_state, n_state;

    logic [AW-1:0]      r_k;
    logic [AW:0]        r_n;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] r_kstep;

    logic               r_p1_vld, r_p1_last;
    logic [PHASE_W-1:0] r_p1_m;
    logic               r_p2_vld, r_p2_last;
    logic signed [PROD_W-1:0] r_pr_re, r_pr_im;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic signed [POWER_W-1:0] r_sq_re, r_sq_im;

    logic               r_out_vld;
    logic [BIN_W-1:0]   r_out_bin;
    logic [POWER_W-1:0] r_out_pow;
    logic               r_out_last;

    logic issue, issue_last, wr_work, load, bin_done, frame_done;
    logic signed [TW_W-1:0] cos_v, sin_v;
    logic signed [EXT_W-1:0] ext_re, ext_im;
    logic signed [WORK_W-1:0] rnd_re, rnd_im;
    logic [2*WORK_W-1:0] work_rdata;
    logic signed [WORK_W-1:0] rd_re, rd_im;

    assign issue_last = (r_n == (AW+1)'(FFT_SIZE - 1));
    assign bin_done   = r_p2_vld && r_p2_last;
    assign frame_done = (r_k == AW'(HALF));
    assign o_idle     = (r_state == S_IDLE);
    assign o_win_addr = i_base + r_n[AW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_MAC;
            S_MAC:   if (bin_done) n_state = S_ROUND;
            S_ROUND: n_state = S_RD;
            S_RD:    n_state = S_SQ;
            S_SQ:    n_state = S_SUM;
            S_SUM: begin
                if (load) n_state = frame_done ? S_IDLE : S_MAC;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        issue   = (r_state == S_MAC) && !r_n[AW];
        wr_work = (r_state == S_ROUND);
        load    = (r_state == S_SUM) && (!r_out_vld || o_out.ready);
    end

    assign cos_v = tw_cos(r_p1_m);
    assign sin_v = tw_cos(r_p1_m + PHASE_W'(48));

    assign ext_re = EXT_W'(r_acc_re) + EXT_W'(16384);
    assign ext_im = EXT_W'(r_acc_im) + EXT_W'(16384);
    assign rnd_re = WORK_W'(ext_re >>> 15);
    assign rnd_im = WORK_W'(ext_im >>> 15);

    sfps_ram #(.WIDTH(2*WORK_W), .DEPTH(FFT_SIZE)) u_work (
        .i_clk  (i_clk),
        .i_we   (wr_work),
        .i_waddr(r_k),
        .i_wdata({rnd_re, rnd_im}),
        .i_raddr(r_k),
        .o_rdata(work_rdata)
    );

    assign rd_re = work_rdata[2*WORK_W-1:WORK_W];
    assign rd_im = work_rdata[WORK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_k       <= '0;
            r_n       <= '0;
        end else begin
            r_state <= n_state;
            r_p1_vld  <= issue;
            r_p1_last <= issue_last;
            r_p1_m    <= r_phase;
            if (issue) begin
                r_n     <= r_n + 1'b1;
                r_phase <= r_phase + r_kstep;
            end
            r_p2_vld  <= r_p1_vld;
            r_p2_last <= r_p1_last;
            r_pr_re   <= i_win_data * cos_v;
            r_pr_im   <= i_win_data * sin_v;
            if (r_p2_vld) begin
                r_acc_re <= r_acc_re + ACC_W'(r_pr_re);
                r_acc_im <= r_acc_im - ACC_W'(r_pr_im);
            end
            if (r_state == S_SQ) begin
                r_sq_re <= rd_re * rd_re;
                r_sq_im <= rd_im * rd_im;
            end
            if (r_state == S_IDLE && i_start) begin
                r_k      <= '0;
                r_kstep  <= '0;
                r_n      <= '0;
                r_phase  <= '0;
                r_acc_re <= '0;
                r_acc_im <= '0;
            end
            if (load) begin
                r_out_bin  <= BIN_W'(r_k);
                r_out_pow  <= r_sq_re + r_sq_im;
                r_out_last <= frame_done;
                r_k        <= r_k + 1'b1;
                r_kstep    <= r_kstep + PHASE_W'(TW_STEP);
                r_n        <= '0;
                r_phase    <= '0;
                r_acc_re   <= '0;
                r_acc_im   <= '0;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.bin_index = r_out_bin;
    assign o_out.bin_power = r_out_pow;
    assign o_out.last_bin  = r_out_last;

    `SFPS_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> r_state == S_IDLE)
    `SFPS_ASSERT(a_last_nyq, i_clk, i_rst_n, (r_out_vld && r_out_last) |-> r_out_bin == BIN_W'(HALF))
    `SFPS_ASSERT(a_rnd_rd, i_clk, i_rst_n, r_state == S_ROUND |=> r_state == S_RD)
    `SFPS_NEVER(a_no_issue_idle, i_clk, i_rst_n, r_p2_vld && r_state != S_MAC)
endmodule

@@ design/strided_fft_power_spectrum_core.sv @@
// Samples are taken only while the engine is idle; samples that do not close a frame emit nothing.
// A frame is a direct DFT with one complex MAC per cycle over FFT_SIZE/2+1 bins, each bin going
// through the MAC, ROUND, RD, SQ and SUM states, with input stalled meanwhile.
// The output register holds one waiting bin; the SUM state waits until that bin is taken.
// Synchronous active-low reset clears the window (per-entry valid bits), pointer, count and
// sets frame_stride to 16; no clearing pass is needed.
module strided_fft_power_spectrum_core
    import sfps_pkg::*;
#(
    parameter int FFT_SIZE = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sfps_in_if.sink             i_in,
    sfps_out_if.source          o_out,
    input  logic                i_cfg_we,
    input  logic [STRIDE_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(FFT_SIZE);

    logic [AW-1:0]       r_wp;
    logic [STRIDE_W-1:0] r_cnt, n_cnt;
    logic [STRIDE_W-1:0] r_stride;
    logic [FFT_SIZE-1:0] r_wvld;
    logic                r_rd_vld;
    logic                r_start;
    logic                accept, eng_idle;
    logic [AW-1:0]       win_addr;
    logic [SAMPLE_W-1:0] win_rdata;
    logic signed [SAMPLE_W-1:0] win_data;

    assign i_in.ready = eng_idle && !r_start;
    assign accept     = i_in.valid && i_in.ready;
    assign n_cnt      = r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_cnt    <= '0;
            r_stride <= STRIDE_RST;
            r_wvld   <= '0;
            r_start  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_start  <= 1'b0;
            r_rd_vld <= r_wvld[win_addr];
            if (i_cfg_we) begin
                r_stride <= i_cfg_data;
            end
            if (accept) begin
                r_wvld[r_wp] <= 1'b1;
                r_wp         <= r_wp + 1'b1;
                if (n_cnt >= r_stride) begin
                    r_cnt   <= '0;
                    r_start <= 1'b1;
                end else begin
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    sfps_ram #(.WIDTH(SAMPLE_W), .DEPTH(FFT_SIZE)) u_window (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(r_wp),
        .i_wdata(i_in.sample),
        .i_raddr(win_addr),
        .o_rdata(win_rdata)
    );

    assign win_data = r_rd_vld ? signed'(win_rdata) : '0;

    sfps_dft_engine #(.FFT_SIZE(FFT_SIZE)) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_base    (r_wp),
        .o_idle    (eng_idle),
        .o_win_addr(win_addr),
        .i_win_data(win_data),
        .o_out     (o_out)
    );
endmodule
